/* src/spim_pkg.sv */
// Shared types and constants for the SPI master with FIFOs.
`default_nettype none
package spim_pkg;
  localparam int unsigned FIFO_DEPTH_DEF = 16;

  typedef enum logic [2:0] {
    ACT_IDLE  = 3'd0,
    ACT_READ  = 3'd1,
    ACT_WRITE = 3'd2,
    ACT_SET   = 3'd3,
    ACT_CLR   = 3'd4
  } act_t;

  localparam logic [1:0] REG_CTRL = 2'd0;
  localparam logic [1:0] REG_TXST = 2'd1;
  localparam logic [1:0] REG_RXST = 2'd2;
  localparam logic [1:0] REG_DATA = 2'd3;

  localparam logic [31:0] CTRL_WRITABLE = 32'h0001_333F;
  localparam logic [31:0] CTRL_RESET    = 32'h0000_1000;

  // One bus access plus the serial input of the same tick.
  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  reg_index;
    logic [31:0] write_data;
    logic        miso;
  } req_t;

  // Result item fields.
  typedef struct packed {
    logic [31:0] read_data;
    logic        sclk;
    logic        mosi;
    logic [3:0]  select_n;
  } rsp_t;

  function automatic logic [31:0] apply_access(input logic [31:0] old_v,
                                               input logic [31:0] val,
                                               input logic [2:0] act);
    logic [31:0] r;
    r = old_v & ~val;
    if (act == ACT_WRITE) r = val;
    else if (act == ACT_SET) r = old_v | val;
    return r;
  endfunction
endpackage
`default_nettype wire

/* src/spim_front.sv */
// Input stage: register each accepted transfer, with skid buffer.
`default_nettype none
module spim_front import spim_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire req_t in_req,
  output logic      q_valid,
  input  wire logic q_ready,
  output req_t      q_req
);
  logic v0_r, v1_r;
  req_t d0_r, d1_r;

  assign in_ready = ~v1_r;
  assign q_valid  = v0_r;
  assign q_req    = d0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      if (q_valid && q_ready) begin
        if (v1_r) begin
          d0_r <= d1_r;
          v1_r <= 1'b0;
          if (in_valid && in_ready) begin
            d1_r <= in_req;
            v1_r <= 1'b1;
          end
        end else begin
          v0_r <= in_valid;
          d0_r <= in_req;
        end
      end else if (in_valid && in_ready) begin
        if (v0_r) begin
          d1_r <= in_req;
          v1_r <= 1'b1;
        end else begin
          d0_r <= in_req;
          v0_r <= 1'b1;
        end
      end
    end
  end

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n) v1_r |-> v0_r)
    else $error("skid entry without head entry");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !(q_valid && q_ready)) |=> v1_r)
    else $error("skid entry lost");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r && !q_ready) |=> (v0_r && $stable(d0_r)))
    else $error("head entry changed while stalled");
endmodule
`default_nettype wire

/* src/spim_core.sv */
// Register file, FIFOs and shifter; one request per tick, registered result.
`default_nettype none
module spim_core import spim_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  output logic      q_ready,
  input  wire req_t q_req,
  output logic      out_valid,
  input  wire logic out_ready,
  output rsp_t      out_rsp
);
  localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PW-1:0] PMAX = PW'(FIFO_DEPTH - 1);
  localparam logic [FW-1:0] FDEP = FW'(FIFO_DEPTH);

  logic [7:0] tx_mem [FIFO_DEPTH];
  logic [7:0] rx_mem [FIFO_DEPTH];

  logic [16:0] ctrl_r, ctrl_nxt;
  logic [FW-1:0] txf_r, txf_nxt, rxf_r, rxf_nxt;
  logic [PW-1:0] txw_r, txw_nxt, txr_r, txr_nxt, rxw_r, rxw_nxt, rxr_r, rxr_nxt;
  logic [7:0] txm_r, txm_nxt, rxm_r, rxm_nxt;
  logic [2:0] err_r, err_nxt;
  logic ign_r, ign_nxt;
  logic [7:0] sb_r, sb_nxt;
  logic [3:0] bc_r, bc_nxt;
  logic [15:0] tc_r, tc_nxt, tc_inc, half;
  logic cl_r, cl_nxt, sh_r, sh_nxt, ob_r, ob_nxt;
  logic ov_r;
  rsp_t rsp_r;
  rsp_t rsp_nxt;
  logic [31:0] rd, img, txst, rxst;
  logic tx_push, rx_push, tx_pop, rx_pop, go, cpha;
  logic [31:0] cw;
  logic [1:0] slv;
  logic low;

  assign q_ready   = ~ov_r | out_ready;
  assign go        = q_valid & q_ready;
  assign out_valid = ov_r;
  assign out_rsp   = rsp_r;

  function automatic logic [PW-1:0] nptr(input logic [PW-1:0] p);
    return (p == PMAX) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    txst = '0;
    txst[20] = (txf_r == '0) && !sh_r;
    txst[19] = err_r[0];
    txst[18] = 8'(txf_r) <= txm_r;
    txst[17] = txf_r == '0;
    txst[16] = txf_r >= FDEP;
    txst[15:8] = txm_r;
    txst[7:0] = 8'(txf_r);
    rxst = '0;
    rxst[31] = ign_r;
    rxst[20] = err_r[2];
    rxst[19] = err_r[1];
    rxst[18] = 8'(rxf_r) >= rxm_r;
    rxst[17] = rxf_r == '0;
    rxst[16] = rxf_r >= FDEP;
    rxst[15:8] = rxm_r;
    rxst[7:0] = 8'(rxf_r);
  end

  always_comb begin
    ctrl_nxt = ctrl_r; txf_nxt = txf_r; rxf_nxt = rxf_r;
    txw_nxt = txw_r; txr_nxt = txr_r; rxw_nxt = rxw_r; rxr_nxt = rxr_r;
    txm_nxt = txm_r; rxm_nxt = rxm_r; err_nxt = err_r; ign_nxt = ign_r;
    sb_nxt = sb_r; bc_nxt = bc_r; tc_nxt = tc_r; cl_nxt = cl_r;
    sh_nxt = sh_r; ob_nxt = ob_r;
    rd = '0; img = '0; tx_push = 1'b0; rx_push = 1'b0; tx_pop = 1'b0; rx_pop = 1'b0;
    tc_inc = tc_r + 16'd1; half = '0; cw = '0; slv = '0; low = 1'b0;
    // bus access
    if (q_req.action == ACT_READ) begin
      unique case (q_req.reg_index)
        REG_CTRL: rd = {15'd0, ctrl_r};
        REG_TXST: rd = txst;
        REG_RXST: rd = rxst;
        default: begin
          if (rxf_r == '0) err_nxt[2] = 1'b1;
          else begin
            rd = {24'd0, rx_mem[rxr_r]};
            rx_pop = 1'b1;
            rxr_nxt = nptr(rxr_r);
          end
        end
      endcase
    end else if (q_req.action == ACT_WRITE || q_req.action == ACT_SET ||
                 q_req.action == ACT_CLR) begin
      unique case (q_req.reg_index)
        REG_CTRL: begin
          cw = apply_access({15'd0, ctrl_r}, q_req.write_data, q_req.action)
               & CTRL_WRITABLE;
          ctrl_nxt = cw[16:0];
        end
        REG_TXST: begin
          img = {12'd0, err_r[0], 3'd0, txm_r, 8'd0};
          img = apply_access(img, q_req.write_data, q_req.action);
          err_nxt[0] = img[19];
          txm_nxt = img[15:8];
        end
        REG_RXST: begin
          img = {ign_r, 10'd0, err_r[2], err_r[1], 3'd0, rxm_r, 8'd0};
          img = apply_access(img, q_req.write_data, q_req.action);
          ign_nxt = img[31];
          err_nxt[2] = img[20];
          err_nxt[1] = img[19];
          rxm_nxt = img[15:8];
        end
        default: begin
          if (q_req.action == ACT_WRITE) begin
            if (txf_r >= FDEP) err_nxt[0] = 1'b1;
            else begin
              tx_push = 1'b1;
              txw_nxt = nptr(txw_r);
            end
          end
        end
      endcase
    end
    // shifter, on state after the access
    cpha = ctrl_nxt[4];
    half = 16'd1 << ctrl_nxt[3:0];
    if (!ctrl_nxt[16]) begin
      if (sh_r) begin
        sh_nxt = 1'b0; bc_nxt = '0; tc_nxt = '0; cl_nxt = 1'b0; ob_nxt = 1'b0;
      end
    end else if (!sh_r) begin
      if (txf_r != '0 || tx_push) begin
        tx_pop = 1'b1;
        sb_nxt = (txf_r != '0) ? tx_mem[txr_r] : q_req.write_data[7:0];
        txr_nxt = nptr(txr_r);
        sh_nxt = 1'b1; bc_nxt = '0; tc_nxt = '0; cl_nxt = 1'b0;
        ob_nxt = cpha ? 1'b0 : sb_nxt[7];
      end
    end else begin
      tc_nxt = tc_inc;
      if (tc_inc >= half) begin
        tc_nxt = '0;
        cl_nxt = ~cl_r;
        if (cl_nxt) begin
          if (cpha) ob_nxt = sb_r[7];
          else sb_nxt = {sb_r[6:0], q_req.miso};
        end else begin
          if (cpha) sb_nxt = {sb_r[6:0], q_req.miso};
          else if (bc_r != 4'd15) ob_nxt = sb_r[7];
        end
        if (bc_r == 4'd15) begin
          if (!ign_nxt) begin
            if ((rxf_r - FW'(rx_pop)) >= FDEP) err_nxt[1] = 1'b1;
            else begin
              rx_push = 1'b1;
              rxw_nxt = nptr(rxw_r);
            end
          end
          sh_nxt = 1'b0; bc_nxt = '0; tc_nxt = '0; cl_nxt = 1'b0; ob_nxt = 1'b0;
        end else bc_nxt = bc_r + 4'd1;
      end
    end
    txf_nxt = txf_r + FW'(tx_push) - FW'(tx_pop);
    rxf_nxt = rxf_r + FW'(rx_push) - FW'(rx_pop);
    // outputs from the state after the tick
    slv = ctrl_nxt[9:8];
    low = ctrl_nxt[13] ? !ctrl_nxt[12] : sh_nxt;
    rsp_nxt.read_data = rd;
    rsp_nxt.sclk = ctrl_nxt[5] ^ cl_nxt;
    rsp_nxt.mosi = sh_nxt & ob_nxt;
    rsp_nxt.select_n = (ctrl_nxt[16] && low) ? ~(4'd1 << slv) : 4'hF;
  end

  always_ff @(posedge clk) begin
    if (go && tx_push) tx_mem[txw_r] <= q_req.write_data[7:0];
    if (go && rx_push) rx_mem[rxw_r] <= sb_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= CTRL_RESET[16:0];
      txf_r <= '0; rxf_r <= '0; txw_r <= '0; txr_r <= '0; rxw_r <= '0; rxr_r <= '0;
      txm_r <= '0; rxm_r <= '0; err_r <= '0; ign_r <= 1'b0; sb_r <= '0;
      bc_r <= '0; tc_r <= '0; cl_r <= 1'b0; sh_r <= 1'b0; ob_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (go) begin
        ctrl_r <= ctrl_nxt; txf_r <= txf_nxt; rxf_r <= rxf_nxt;
        txw_r <= txw_nxt; txr_r <= txr_nxt; rxw_r <= rxw_nxt; rxr_r <= rxr_nxt;
        txm_r <= txm_nxt; rxm_r <= rxm_nxt; err_r <= err_nxt; ign_r <= ign_nxt;
        sb_r <= sb_nxt; bc_r <= bc_nxt; tc_r <= tc_nxt; cl_r <= cl_nxt;
        sh_r <= sh_nxt; ob_r <= ob_nxt;
        rsp_r <= rsp_nxt;
        ov_r <= 1'b1;
      end else if (out_ready) ov_r <= 1'b0;
    end
  end

  a_txf: assert property (@(posedge clk) disable iff (!rst_n) txf_r <= FDEP)
    else $error("tx fill out of range");
  a_rxf: assert property (@(posedge clk) disable iff (!rst_n) rxf_r <= FDEP)
    else $error("rx fill out of range");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !sh_r |-> (bc_r == '0 && tc_r == '0 && !cl_r))
    else $error("shifter counters busy while idle");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> (ov_r && $stable(rsp_r)))
    else $error("result lost under stall");
endmodule
`default_nettype wire

/* src/spi_master_with_fifos_top.sv */
// Top level of the SPI master with transmit and receive FIFOs.
// Usage: each input transfer on in_* is one peripheral tick carrying a bus
// access (idle, read, write, set bits, clear bits) to CTRL, TX_STAT, RX_STAT
// or DATA, plus the MISO level. Each accepted transfer yields exactly one
// result transfer on out_* with the read value and the SCLK, MOSI and
// active-low select levels after that tick.
// Each transfer passes the input register, then the result register.
// Throughput: one transfer per cycle while out_tready is high, with
// spim_core updating registers and shifter for each accepted transfer.
// Reset (rst_n low, synchronous) empties both FIFOs, stops the shifter and
// loads CTRL with the manual select level high. When the receiver stalls,
// the result register holds, then the input skid stage fills and in_tready
// drops; no transfer is lost.
`default_nettype none
module spi_master_with_fifos_top import spim_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [2:0] action, [4:3] reg_index, [36:5] write_data, [37] miso, [39:38] zero
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [31:0] read_data, [32] sclk, [33] mosi, [37:34] select_n, [39:38] zero
  output logic [39:0]      out_tdata
);
  req_t req_in, q_req;
  rsp_t rsp;
  logic q_valid, q_ready;

  assign req_in.action     = in_tdata[2:0];
  assign req_in.reg_index  = in_tdata[4:3];
  assign req_in.write_data = in_tdata[36:5];
  assign req_in.miso       = in_tdata[37];

  spim_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_req(req_in), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  spim_core #(.FIFO_DEPTH(FIFO_DEPTH)) u_core (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_rsp(rsp)
  );

  assign out_tdata = {2'b00, rsp.select_n, rsp.mosi, rsp.sclk, rsp.read_data};
endmodule
`default_nettype wire
